### src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/esdsm_pkg.sv
// Package: widths, constants and helpers of the encoder speed monitor.
`default_nettype none
package esdsm_pkg;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Configuration port widths
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 20;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RPM_PER_COUNT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_LIMIT     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_LIMIT   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_FAST      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_MEDIUM    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_SLOW      = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_PER_COUNT = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STALL_PERIODS  = 4'd7;

    // Direction codes
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    // Motor running threshold on |command| and direction dead band
    localparam logic [16:0]        MOTOR_RUN_LIMIT = 17'd30;
    localparam logic signed [15:0] DIR_DEAD_BAND   = 16'sd2;

    // Gain ceiling, Q8 unity
    localparam logic [8:0] GAIN_MAX = 9'd256;

    // Saturation bounds, held at product width
    localparam logic signed [MUL_P_W-1:0] S24_MAX = 43'sd8388607;
    localparam logic signed [MUL_P_W-1:0] S24_MIN = -43'sd8388608;

    // Clamp a wide signed value to 24 bits
    function automatic logic signed [23:0] sat24(input logic signed [MUL_P_W-1:0] v);
        logic signed [23:0] r;
        if (v > S24_MAX)
            r = 24'sh7FFFFF;
        else if (v < S24_MIN)
            r = 24'sh800000;
        else
            r = v[23:0];
        return r;
    endfunction

endpackage
`default_nettype wire

### src/esdsm_ifs.sv
// Interfaces: sample input, result output and configuration write channels.
`default_nettype none
interface esdsm_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] count_delta;
    logic signed [15:0] motor_command;
    logic               clear_totals;

    modport source (output valid, count_delta, motor_command, clear_totals, input ready);
    modport sink   (input valid, count_delta, motor_command, clear_totals, output ready);
endinterface

interface esdsm_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] instant_rpm;
    logic signed [23:0] smoothed_rpm;
    logic [1:0]         direction;
    logic signed [31:0] pulse_total;
    logic [47:0]        distance_total;
    logic               stalled;

    modport source (output valid, instant_rpm, smoothed_rpm, direction, pulse_total,
                    distance_total, stalled, input ready);
    modport sink   (input valid, instant_rpm, smoothed_rpm, direction, pulse_total,
                    distance_total, stalled, output ready);
endinterface

interface esdsm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [esdsm_pkg::CFG_IDX_W-1:0]    index;
    logic [esdsm_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### src/esdsm_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none
module esdsm_mul (
    input  wire logic                               clk,
    input  wire logic signed [esdsm_pkg::MUL_A_W-1:0] a,
    input  wire logic signed [esdsm_pkg::MUL_B_W-1:0] b,
    output logic signed [esdsm_pkg::MUL_P_W-1:0]      prod_reg
);
    import esdsm_pkg::*;

    logic signed [MUL_P_W-1:0] prod_next;

    // One product per cycle, sign-extended operands
    assign prod_next = MUL_P_W'(a) * MUL_P_W'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end
endmodule
`default_nettype wire

### src/encoder_speed_distance_stall_monitor.sv
// Top level: encoder speed, distance and stall monitor.
// Usage:
//   sample : one transaction per encoder sample period carrying count_delta,
//            motor_command and clear_totals.
//   result : one transaction per sample carrying instant and smoothed speed
//            (1/16 RPM), direction, pulse and distance totals and stall flag.
//   cfg    : register writes (index, data); always ready, take effect at once,
//            to be written only while no sample is in flight.
// Timing: a sample passes through a sequencer that uses one shared multiplier
//   three times (speed scaling, distance increment, filter step). The result
//   register loads as the sequencer leaves its last step; sample.ready rises
//   at that same edge, so a new sample is taken only once the previous one
//   has left the sequencer.
// Stall: a result waiting at the output does not block the next sample; the
//   sequencer holds in its last step only when the output register still holds
//   the previous result and result.ready is low.
// Reset: configuration registers return to their default values, filter, still counter and
//   totals to zero; no result is pending.
`default_nettype none
module encoder_speed_distance_stall_monitor (
    input wire logic    clk,
    input wire logic    rst_n,
    esdsm_in_if.sink    sample,
    esdsm_out_if.source result,
    esdsm_cfg_if.sink   cfg
);
    import esdsm_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MRPM = 7'b0000010,
        S_INST = 7'b0000100,
        S_GAIN = 7'b0001000,
        S_MEMA = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [15:0] rpm_per_count_reg;
    logic [19:0] fast_limit_reg;
    logic [19:0] medium_limit_reg;
    logic [8:0]  gain_fast_reg;
    logic [8:0]  gain_medium_reg;
    logic [8:0]  gain_slow_reg;
    logic [15:0] dist_per_count_reg;
    logic [15:0] stall_periods_reg;

    // Long-lived state
    logic signed [23:0] ema_reg, ema_next;
    logic [15:0]        still_reg, still_next;
    logic signed [31:0] pulse_reg, pulse_next;
    logic [47:0]        dist_reg, dist_next;

    // Per-sample working registers
    logic signed [15:0] delta_reg, delta_next;
    logic signed [15:0] cmd_reg, cmd_next;
    logic signed [23:0] inst_reg, inst_next;
    logic signed [24:0] diff_reg, diff_next;
    logic [8:0]         gain_reg, gain_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic signed [23:0] o_inst_reg, o_inst_next;
    logic signed [23:0] o_ema_reg, o_ema_next;
    logic [1:0]         o_dir_reg, o_dir_next;
    logic signed [31:0] o_pulse_reg, o_pulse_next;
    logic [47:0]        o_dist_reg, o_dist_next;
    logic               o_stall_reg, o_stall_next;

    // Shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;

    esdsm_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    // Derived values
    logic [16:0]               mag;
    logic [16:0]               cmd_mag;
    logic signed [MUL_P_W-1:0] prod_rnd;
    logic signed [24:0]        diff_w;
    logic [24:0]               change;
    logic [8:0]                gain_sel;
    logic [48:0]               dist_sum;
    logic signed [MUL_P_W-1:0] ema_sum;
    logic signed [32:0]        pulse_sum;
    logic                      running;
    logic                      still;
    logic                      in_acc;
    logic                      out_free;

    assign in_acc   = sample.valid && sample.ready;
    assign out_free = !out_valid_reg || result.ready;

    assign mag      = delta_reg[15] ? -17'(delta_reg) : 17'(delta_reg);
    assign cmd_mag  = cmd_reg[15] ? -17'(cmd_reg) : 17'(cmd_reg);
    assign prod_rnd = (prod + MUL_P_W'(128)) >>> 8;
    assign diff_w   = 25'(inst_reg) - 25'(ema_reg);
    assign change   = diff_w[24] ? 25'(-diff_w) : 25'(diff_w);
    assign dist_sum = {1'b0, dist_reg} + {17'd0, prod[31:0]};
    assign ema_sum  = MUL_P_W'(ema_reg) + prod_rnd;
    assign pulse_sum = 33'(pulse_reg) + 33'(delta_reg);
    assign running  = cmd_mag > MOTOR_RUN_LIMIT;
    assign still    = mag <= 17'd1;

    // Gain choice by size of the change, fast test first
    always_comb
    begin
        priority if (change > {5'd0, fast_limit_reg})
            gain_sel = gain_fast_reg;
        else if (change > {5'd0, medium_limit_reg})
            gain_sel = gain_medium_reg;
        else
            gain_sel = gain_slow_reg;
    end

    // Multiplier operand selection per step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MRPM:
            begin
                mul_a = MUL_A_W'(delta_reg);
                mul_b = {1'b0, rpm_per_count_reg};
            end
            S_INST:
            begin
                mul_a = {9'd0, mag};
                mul_b = {1'b0, dist_per_count_reg};
            end
            S_MEMA:
            begin
                mul_a = MUL_A_W'(diff_reg);
                mul_b = {8'd0, gain_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        ema_next       = ema_reg;
        still_next     = still_reg;
        pulse_next     = pulse_reg;
        dist_next      = dist_reg;
        delta_next     = delta_reg;
        cmd_next       = cmd_reg;
        inst_next      = inst_reg;
        diff_next      = diff_reg;
        gain_next      = gain_reg;
        out_valid_next = out_valid_reg && !result.ready;
        o_inst_next    = o_inst_reg;
        o_ema_next     = o_ema_reg;
        o_dir_next     = o_dir_reg;
        o_pulse_next   = o_pulse_reg;
        o_dist_next    = o_dist_reg;
        o_stall_next   = o_stall_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    delta_next = sample.count_delta;
                    cmd_next   = sample.motor_command;
                    if (sample.clear_totals)
                    begin
                        pulse_next = '0;
                        dist_next  = '0;
                    end
                    state_next = S_MRPM;
                end
            end
            S_MRPM:
            begin
                state_next = S_INST;
            end
            S_INST:
            begin
                inst_next  = sat24(prod_rnd);
                state_next = S_GAIN;
            end
            S_GAIN:
            begin
                diff_next  = diff_w;
                gain_next  = (gain_sel > GAIN_MAX) ? GAIN_MAX : gain_sel;
                dist_next  = dist_sum[48] ? '1 : dist_sum[47:0];
                state_next = S_MEMA;
            end
            S_MEMA:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                ema_next = sat24(ema_sum);
                if (pulse_sum[32] != pulse_sum[31])
                    pulse_next = pulse_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
                else
                    pulse_next = pulse_sum[31:0];
                if (running && still)
                    still_next = (still_reg == 16'hFFFF) ? still_reg : still_reg + 16'd1;
                else
                    still_next = '0;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_inst_next    = inst_reg;
                    o_ema_next     = ema_reg;
                    o_pulse_next   = pulse_reg;
                    o_dist_next    = dist_reg;
                    o_stall_next   = still_reg > stall_periods_reg;
                    priority if (delta_reg > DIR_DEAD_BAND)
                        o_dir_next = DIR_FWD;
                    else if (delta_reg < -DIR_DEAD_BAND)
                        o_dir_next = DIR_REV;
                    else
                        o_dir_next = DIR_STOP;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            ema_reg       <= '0;
            still_reg     <= '0;
            pulse_reg     <= '0;
            dist_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            ema_reg       <= ema_next;
            still_reg     <= still_next;
            pulse_reg     <= pulse_next;
            dist_reg      <= dist_next;
        end
    end

    // Working and output payload registers
    always_ff @(posedge clk)
    begin
        delta_reg   <= delta_next;
        cmd_reg     <= cmd_next;
        inst_reg    <= inst_next;
        diff_reg    <= diff_next;
        gain_reg    <= gain_next;
        o_inst_reg  <= o_inst_next;
        o_ema_reg   <= o_ema_next;
        o_dir_reg   <= o_dir_next;
        o_pulse_reg <= o_pulse_next;
        o_dist_reg  <= o_dist_next;
        o_stall_reg <= o_stall_next;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpm_per_count_reg  <= 16'd5120;
            fast_limit_reg     <= 20'd800;
            medium_limit_reg   <= 20'd160;
            gain_fast_reg      <= 9'd205;
            gain_medium_reg    <= 9'd128;
            gain_slow_reg      <= 9'd51;
            dist_per_count_reg <= 16'd546;
            stall_periods_reg  <= 16'd50;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_RPM_PER_COUNT:  rpm_per_count_reg  <= cfg.data[15:0];
                REG_FAST_LIMIT:     fast_limit_reg     <= cfg.data;
                REG_MEDIUM_LIMIT:   medium_limit_reg   <= cfg.data;
                REG_GAIN_FAST:      gain_fast_reg      <= cfg.data[8:0];
                REG_GAIN_MEDIUM:    gain_medium_reg    <= cfg.data[8:0];
                REG_GAIN_SLOW:      gain_slow_reg      <= cfg.data[8:0];
                REG_DIST_PER_COUNT: dist_per_count_reg <= cfg.data[15:0];
                REG_STALL_PERIODS:  stall_periods_reg  <= cfg.data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // Port drive
    assign cfg.ready             = 1'b1;
    assign sample.ready          = (state_reg == S_IDLE);
    assign result.valid          = out_valid_reg;
    assign result.instant_rpm    = o_inst_reg;
    assign result.smoothed_rpm   = o_ema_reg;
    assign result.direction      = o_dir_reg;
    assign result.pulse_total    = o_pulse_reg;
    assign result.distance_total = o_dist_reg;
    assign result.stalled        = o_stall_reg;
endmodule
`default_nettype wire

### src/esdsm_checker.sv
// Port-level checker for the encoder speed monitor, with its bind.
`default_nettype none
`include "assert_macros.svh"
module esdsm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [23:0] out_smoothed,
    input wire logic [1:0]  out_dir,
    input wire logic [47:0] out_dist,
    input wire logic        out_stalled
);
    import esdsm_pkg::*;

    logic in_acc;
    logic out_hold;

    assign in_acc   = in_valid && in_ready;
    assign out_hold = out_valid && !out_ready;

    // A stalled result stays valid and keeps its smoothed speed and distance
    `ASSERT_NXT(a_out_hold, clk, rst_n, out_hold,
                out_valid && $stable(out_smoothed) && $stable(out_dist))
    // The sequencer is busy right after taking a sample
    `ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_acc, !in_ready)
    // Only defined direction codes appear
    `ASSERT_IMP(a_dir_code, clk, rst_n, out_valid,
                out_dir == DIR_STOP || out_dir == DIR_FWD || out_dir == DIR_REV)
    // A stall needs a still wheel, so no direction is reported with it
    `ASSERT_IMP(a_stall_still, clk, rst_n, out_valid && out_stalled, out_dir == DIR_STOP)
endmodule

bind encoder_speed_distance_stall_monitor esdsm_checker u_esdsm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sample.valid),
    .in_ready     (sample.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_smoothed (result.smoothed_rpm),
    .out_dir      (result.direction),
    .out_dist     (result.distance_total),
    .out_stalled  (result.stalled)
);
`default_nettype wire

### tb/sv/encoder_speed_distance_stall_monitor_test.sv
// Self-checking testbench for the encoder speed, distance and stall monitor.
module encoder_speed_distance_stall_monitor_test;
    import esdsm_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 20;
    localparam int REPORT_LIMIT    = 10;
    localparam int REG_COUNT       = 8;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 75;
    localparam int STILL_RUN_ITEMS = 40;
    localparam int LARGE_RUN_ITEMS = 16;

    localparam longint RPM_MAX   = 64'sd8388607;
    localparam longint RPM_MIN   = -64'sd8388608;
    localparam longint PULSE_MAX = 64'sd2147483647;
    localparam longint PULSE_MIN = -64'sd2147483648;
    localparam longint DIST_MAX  = 64'sd281474976710655;
    localparam logic [15:0] STILL_MAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0] rpm_per_count;
        logic [19:0] fast_limit;
        logic [19:0] medium_limit;
        logic [8:0]  gain_fast;
        logic [8:0]  gain_medium;
        logic [8:0]  gain_slow;
        logic [15:0] distance_per_count;
        logic [15:0] stall_periods;
    } monitor_cfg_t;

    typedef struct packed {
        logic [15:0] count_delta;
        logic [15:0] motor_command;
        logic        clear_totals;
    } sample_t;

    typedef struct packed {
        logic [23:0] instant_rpm;
        logic [23:0] smoothed_rpm;
        logic [1:0]  direction;
        logic [31:0] pulse_total;
        logic [47:0] distance_total;
        logic        stalled;
    } speed_result_t;

    localparam monitor_cfg_t CFG_AT_RESET = {16'd5120, 20'd800, 20'd160, 9'd205, 9'd128,
                                             9'd51, 16'd546, 16'd50};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    esdsm_in_if  sample_ch ();
    esdsm_out_if result_ch ();
    esdsm_cfg_if cfg_ch ();

    encoder_speed_distance_stall_monitor DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Predictor state, mirroring the block after reset
    monitor_cfg_t       cfg_shadow     = CFG_AT_RESET;
    logic signed [23:0] ema_model      = '0;
    logic [15:0]        still_model    = '0;
    logic signed [31:0] pulse_model    = '0;
    logic [47:0]        distance_model = '0;

    speed_result_t pending_results[$];
    int error_count = 0;
    int sink_hold   = 0;
    bit jitter_on   = 1'b0;

    // Clock, period 2
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint limit_to_s24(input longint v);
        if (v > RPM_MAX)
            return RPM_MAX;
        if (v < RPM_MIN)
            return RPM_MIN;
        return v;
    endfunction

    // Advance the predictor by one sample period and return the expected result
    function automatic speed_result_t predict_speed_and_totals(input sample_t s);
        speed_result_t r;
        longint delta, cmd, mag, inst, ema, diff, change, gain, psum, dsum;
        delta = longint'($signed(s.count_delta));
        cmd   = longint'($signed(s.motor_command));
        mag   = (delta < 0) ? -delta : delta;
        if (s.clear_totals)
        begin
            pulse_model    = '0;
            distance_model = '0;
        end
        // speed scaling, rounded half up
        inst   = limit_to_s24((delta * longint'(cfg_shadow.rpm_per_count) + 128) >>> 8);
        // adaptive filter, gain chosen on the size of the step, fast test first
        ema    = longint'(ema_model);
        diff   = inst - ema;
        change = (diff < 0) ? -diff : diff;
        if (change > longint'(cfg_shadow.fast_limit))
            gain = longint'(cfg_shadow.gain_fast);
        else if (change > longint'(cfg_shadow.medium_limit))
            gain = longint'(cfg_shadow.gain_medium);
        else
            gain = longint'(cfg_shadow.gain_slow);
        if (gain > longint'(GAIN_MAX))
            gain = longint'(GAIN_MAX);
        ema_model = 24'(limit_to_s24(ema + ((gain * diff + 128) >>> 8)));
        // direction with dead band
        if (delta > DIR_DEAD_BAND)
            r.direction = DIR_FWD;
        else if (delta < -DIR_DEAD_BAND)
            r.direction = DIR_REV;
        else
            r.direction = DIR_STOP;
        // saturating totals
        psum = longint'(pulse_model) + delta;
        if (psum > PULSE_MAX)
            psum = PULSE_MAX;
        if (psum < PULSE_MIN)
            psum = PULSE_MIN;
        pulse_model = 32'(psum);
        dsum = longint'(distance_model) + mag * longint'(cfg_shadow.distance_per_count);
        if (dsum > DIST_MAX)
            dsum = DIST_MAX;
        distance_model = 48'(dsum);
        // still counter: motor running and wheel still
        if ((((cmd < 0) ? -cmd : cmd) > longint'(MOTOR_RUN_LIMIT)) && (mag <= 1))
        begin
            if (still_model != STILL_MAX)
                still_model = still_model + 16'd1;
        end
        else
            still_model = '0;
        r.instant_rpm    = inst[23:0];
        r.smoothed_rpm   = ema_model;
        r.pulse_total    = pulse_model;
        r.distance_total = distance_model;
        r.stalled        = still_model > cfg_shadow.stall_periods;
        return r;
    endfunction

    // Idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        roll = int'($urandom_range(0, 99));
        if (!jitter_on || roll < 55)
            return 0;
        if (roll < 85)
            return int'($urandom_range(1, 3));
        if (roll < 95)
            return int'($urandom_range(4, 9));
        return int'($urandom_range(10, 40));
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        case ($urandom_range(0, 9))
            0, 1, 2: s.count_delta = 16'($urandom_range(0, 10) - 5);
            3:
            begin
                case ($urandom_range(0, 5))
                    0: s.count_delta = 16'h8000;
                    1: s.count_delta = 16'h7FFF;
                    2: s.count_delta = -16'sd30000;
                    3: s.count_delta = 16'sd30000;
                    4: s.count_delta = DIR_DEAD_BAND;
                    default: s.count_delta = -DIR_DEAD_BAND;
                endcase
            end
            4, 5, 6: s.count_delta = 16'($urandom_range(0, 4000) - 2000);
            default: s.count_delta = 16'($urandom_range(0, 16'hFFFF));
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                s.motor_command = 16'($urandom_range(28, 33));
                if ($urandom_range(0, 1) == 1)
                    s.motor_command = -s.motor_command;
            end
            4, 5, 6, 7: s.motor_command = 16'($urandom_range(0, 16'hFFFF));
            default: s.motor_command = '0;
        endcase
        s.clear_totals = ($urandom_range(0, 19) == 0);
        return s;
    endfunction

    // Motor commanded to run, wheel within one count of still
    function automatic sample_t still_sample();
        sample_t s;
        s.count_delta = 16'($urandom_range(0, 2) - 1);
        if ($urandom_range(0, 15) == 0)
            s.motor_command = 16'h8000;
        else
        begin
            s.motor_command = 16'($urandom_range(31, 32767));
            if ($urandom_range(0, 1) == 1)
                s.motor_command = -s.motor_command;
        end
        s.clear_totals = ($urandom_range(0, 31) == 0);
        return s;
    endfunction

    // Offer one sample; entered and left at a falling edge, valid left high
    task automatic send_sample(input sample_t s);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            sample_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid         = 1'b1;
        sample_ch.count_delta   = s.count_delta;
        sample_ch.motor_command = s.motor_command;
        sample_ch.clear_totals  = s.clear_totals;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        pending_results.push_back(predict_speed_and_totals(s));
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        sample_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Write all registers, then one unused index; only while idle
    task automatic apply_config(input monitor_cfg_t c);
        logic [3:0]  idx;
        logic [19:0] d;
        for (int i = 0; i <= REG_COUNT; i++)
        begin
            // junk in the bits a register does not hold
            d = 20'($urandom_range(0, 20'hFFFFF));
            if (i < REG_COUNT)
                idx = 4'(i);
            else
                idx = 4'(REG_COUNT + int'($urandom_range(0, 7)));
            case (idx)
                REG_RPM_PER_COUNT:  d[15:0] = c.rpm_per_count;
                REG_FAST_LIMIT:     d = c.fast_limit;
                REG_MEDIUM_LIMIT:   d = c.medium_limit;
                REG_GAIN_FAST:      d[8:0] = c.gain_fast;
                REG_GAIN_MEDIUM:    d[8:0] = c.gain_medium;
                REG_GAIN_SLOW:      d[8:0] = c.gain_slow;
                REG_DIST_PER_COUNT: d[15:0] = c.distance_per_count;
                REG_STALL_PERIODS:  d[15:0] = c.stall_periods;
                default: ;
            endcase
            cfg_ch.valid = 1'b1;
            cfg_ch.index = idx;
            cfg_ch.data  = d;
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            @(negedge clk);
        end
        cfg_ch.valid = 1'b0;
        cfg_shadow   = c;
    endtask

    // Field extremes, dead band edges, run limit edges and clear at reset settings
    task automatic test_directed_defaults();
        send_sample({16'sd0, 16'sd0, 1'b0});
        send_sample({16'sd1, 16'sd31, 1'b0});
        send_sample({-16'sd1, -16'sd31, 1'b0});
        send_sample({16'sd2, 16'sd30, 1'b0});
        send_sample({-16'sd2, -16'sd30, 1'b0});
        send_sample({16'sd3, 16'sh7FFF, 1'b0});
        send_sample({-16'sd3, 16'sh8000, 1'b0});
        send_sample({16'sd30000, 16'sd100, 1'b0});
        send_sample({-16'sd30000, -16'sd100, 1'b0});
        send_sample({16'sh7FFF, 16'sd0, 1'b0});
        send_sample({16'sh8000, 16'sd1000, 1'b0});
        send_sample({16'sd0, 16'sd0, 1'b1});
        send_sample({16'sd5, -16'sd31, 1'b0});
        wait_results_drained();
    endtask

    // Gains above unity, limits out of order, short stall timeout
    task automatic test_directed_special_cases();
        monitor_cfg_t c;
        c = {16'hFFFF, 20'd100, 20'd5000, 9'd511, 9'd300, 9'd0, 16'hFFFF, 16'd1};
        apply_config(c);
        send_sample({16'sh7FFF, 16'sd31, 1'b0});
        send_sample({16'sh8000, 16'sd31, 1'b0});
        send_sample({16'sd4, 16'sd0, 1'b0});
        send_sample({16'sd0, 16'sd31, 1'b0});
        send_sample({16'sd1, 16'sd31, 1'b0});
        send_sample({-16'sd1, -16'sd31, 1'b0});
        send_sample({16'sd0, 16'sd30, 1'b0});
        send_sample({16'sd0, 16'sh8000, 1'b0});
        send_sample({16'sd0, 16'sh8000, 1'b0});
        send_sample({16'sd2, 16'sd31, 1'b1});
        send_sample({16'sd1, 16'sd31, 1'b0});
        wait_results_drained();
    endtask

    // Output held off while the sender keeps offering, then a full drain
    task automatic test_backpressure();
        jitter_on = 1'b0;
        @(posedge clk);
        sink_hold = HOLD_OFF_CYCLES;
        @(negedge clk);
        repeat (20)
            send_sample(random_sample());
        wait_results_drained();
    endtask

    // Random content over several register settings, mostly stall-shaped runs
    task automatic test_random_phases();
        monitor_cfg_t c;
        sample_t s;
        int sent, run_len, cap;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_results_drained();
            c.rpm_per_count      = 16'($urandom_range(0, 16'hFFFF));
            c.gain_fast          = 9'($urandom_range(0, 9'h1FF));
            c.gain_medium        = 9'($urandom_range(0, 9'h1FF));
            c.gain_slow          = 9'($urandom_range(0, 9'h1FF));
            c.distance_per_count = 16'($urandom_range(0, 16'hFFFF));
            if ($urandom_range(0, 3) == 0)
            begin
                c.fast_limit    = 20'($urandom_range(0, 20'hFFFFF));
                c.medium_limit  = 20'($urandom_range(0, 20'hFFFFF));
                c.stall_periods = 16'($urandom_range(0, 16'hFFFF));
            end
            else
            begin
                c.fast_limit    = 20'($urandom_range(0, 40000));
                c.medium_limit  = 20'($urandom_range(0, c.fast_limit));
                c.stall_periods = 16'($urandom_range(0, 12));
            end
            case (phase)
                0: c = CFG_AT_RESET;
                1: c = '0;
                2: c = {16'hFFFF, 20'hFFFFF, 20'hFFFFF, 9'h1FF, 9'h1FF, 9'h1FF,
                        16'hFFFF, 16'hFFFF};
                3:
                begin
                    // fast limit below medium
                    c.medium_limit = 20'($urandom_range(400, 40000));
                    c.fast_limit   = 20'($urandom_range(0, c.medium_limit));
                end
                default: ;
            endcase
            apply_config(c);
            // one phase without idling on either side
            jitter_on = (phase != 4);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) < 6)
                begin
                    cap = int'(cfg_shadow.stall_periods);
                    if (cap > 60)
                        cap = 60;
                    run_len = int'($urandom_range(0, cap + 3));
                    repeat (run_len)
                        send_sample(still_sample());
                    sent = sent + run_len;
                end
                s = random_sample();
                send_sample(s);
                sent++;
            end
        end
        wait_results_drained();
    endtask

    // The largest timeout never flags a stall, however long the wheel stays still
    task automatic test_largest_stall_timeout();
        monitor_cfg_t c;
        jitter_on = 1'b0;
        c = cfg_shadow;
        c.stall_periods = STILL_MAX;
        apply_config(c);
        repeat (STILL_RUN_ITEMS)
            send_sample(still_sample());
        send_sample({16'sd100, 16'sd31, 1'b0});
        wait_results_drained();
    endtask

    // Largest distance steps and negative pulse steps after a clear
    task automatic test_large_totals();
        monitor_cfg_t c;
        sample_t s;
        jitter_on = 1'b0;
        c = cfg_shadow;
        c.distance_per_count = 16'hFFFF;
        apply_config(c);
        send_sample({16'sh8000, 16'sd0, 1'b1});
        s.count_delta  = 16'h8000;
        s.clear_totals = 1'b0;
        repeat (LARGE_RUN_ITEMS)
        begin
            s.motor_command = 16'($urandom_range(0, 16'hFFFF));
            send_sample(s);
        end
        repeat (3)
            send_sample({16'sh7FFF, 16'sd50, 1'b0});
        wait_results_drained();
    endtask

    task automatic check_field(input string what, input logic [47:0] want,
                               input logic [47:0] got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("mismatch on %s: expected %h, got %h", what, want, got);
        end
    endtask

    // Receiver: random idling plus a hold-off counted down here
    initial
    begin
        int gap;
        gap = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                result_ch.ready = 1'b0;
                sink_hold--;
            end
            else if (gap > 0)
            begin
                result_ch.ready = 1'b0;
                gap--;
            end
            else
            begin
                result_ch.ready = 1'b1;
                if ($urandom_range(0, 2) == 0)
                    gap = pick_gap();
            end
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        speed_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("result transaction with no sample pending");
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("instant_rpm", 48'(want.instant_rpm),
                            48'($unsigned(result_ch.instant_rpm)));
                check_field("smoothed_rpm", 48'(want.smoothed_rpm),
                            48'($unsigned(result_ch.smoothed_rpm)));
                check_field("direction", 48'(want.direction), 48'(result_ch.direction));
                check_field("pulse_total", 48'(want.pulse_total),
                            48'($unsigned(result_ch.pulse_total)));
                check_field("distance_total", want.distance_total, result_ch.distance_total);
                check_field("stalled", 48'(want.stalled), 48'(result_ch.stalled));
            end
        end
    end

    // Watchdog: too long without any transaction ends the run
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("encoder_speed_distance_stall_monitor_test: FAIL");
        $finish;
    end

    // Test sequence
    initial
    begin
        sample_ch.valid         = 1'b0;
        sample_ch.count_delta   = '0;
        sample_ch.motor_command = '0;
        sample_ch.clear_totals  = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = '0;
        cfg_ch.data             = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        test_directed_defaults();
        test_directed_special_cases();
        test_backpressure();
        test_random_phases();
        test_largest_stall_timeout();
        test_large_totals();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("encoder_speed_distance_stall_monitor_test: PASS");
        else
            $display("encoder_speed_distance_stall_monitor_test: FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/esdsm_pkg.sv
src/esdsm_ifs.sv
src/esdsm_mul.sv
src/encoder_speed_distance_stall_monitor.sv
src/esdsm_checker.sv
tb/sv/encoder_speed_distance_stall_monitor_test.sv
